// ===== rtl/core/esws_pkg.sv =====
// shared types, constants and table builders of the enveloped sine wav stream
// no dependencies; imported by esws_sample_unit and enveloped_sine_wav_stream_core
`default_nettype none

package esws_pkg;

  localparam int unsigned SINE_TABLE_DEPTH = 1024;
  localparam int unsigned SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned PCM_RATE         = 44100;

  localparam int unsigned WORD_W       = 16;
  localparam int unsigned DUR_W        = 16;
  localparam int unsigned HEADER_WORDS = 22;
  localparam int unsigned POS_W        = 5;
  localparam int unsigned IDX_W        = 22;
  localparam logic [IDX_W-1:0] INDEX_MAX = '1;

  // apb register map
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned REG_SEL_BIT = 2;
  typedef enum logic {
    REG_PHASE_STEP,
    REG_DURATION
  } reg_e;

  // sample count n = duration * rate / 1000, done as * RATE_NUM / RATE_DEN
  localparam int unsigned RATE_NUM   = PCM_RATE / 100;
  localparam int unsigned RATE_DEN   = 1000 / 100;
  localparam int unsigned RATE_NUM_W = $clog2(RATE_NUM + 1);
  localparam int unsigned Y_W        = DUR_W + RATE_NUM_W;
  localparam int unsigned NPROD_W    = Y_W + 32;
  localparam logic [31:0] DEN_RECIP  = 32'((64'd1 << 32) / RATE_DEN);
  localparam int unsigned NCNT_LAT   = 3;
  localparam int unsigned WAIT_W     = $clog2(NCNT_LAT + 1);

  // envelope
  localparam int unsigned RAMP_LEN   = 600;
  localparam int unsigned RAMP_W     = $clog2(RAMP_LEN + 1);
  localparam int unsigned RAMP_SQ    = RAMP_LEN * RAMP_LEN;
  localparam int unsigned PROD_W     = $clog2(RAMP_SQ + 1);
  localparam int unsigned ENV_FRAC   = 16;
  localparam int unsigned ENV_SHIFT  = 50;
  localparam logic [31:0] ENV_RECIP  = 32'((64'd1 << ENV_SHIFT) / RAMP_SQ);
  localparam int unsigned EPROD_W    = PROD_W + 32;
  localparam int unsigned EST_W      = EPROD_W - (ENV_SHIFT - ENV_FRAC);
  localparam int unsigned SC_W       = PROD_W + ENV_FRAC;

  // amplitude scaling
  localparam int unsigned AMPLITUDE  = 12000;
  localparam int unsigned AMP_W      = $clog2(AMPLITUDE + 1);
  localparam int unsigned MAG_W      = 15 + ENV_FRAC;
  localparam int unsigned AP_W       = MAG_W + AMP_W;
  localparam int unsigned AMP_SHIFT  = 31;

  localparam int unsigned SAMPLE_LAT = 6;

  localparam logic [31:0] RATE_V      = 32'(PCM_RATE);
  localparam logic [31:0] BYTE_RATE_V = 32'(2 * PCM_RATE);

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ROM_DIV     = 64'(2 * SINE_TABLE_DEPTH);

  typedef enum logic [1:0] {
    ST_READY,
    ST_CALC,
    ST_PUT
  } state_e;

  typedef struct packed {
    logic [SINE_IDX_W-1:0] tbl_idx;
    logic                  neg;
    logic [RAMP_W-1:0]     ramp_a;
    logic [RAMP_W-1:0]     ramp_b;
  } smp_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] word;
  } smp_rsp_t;

  typedef logic [WORD_W-1:0] sine_rom_t [SINE_TABLE_DEPTH];

  // quarter-wave table, q30 taylor series through x^11
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t       rom;
    longint unsigned x;
    longint unsigned term;
    longint unsigned v;
    longint          sum;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      x    = ((64'(2 * k) + 64'd1) * HALF_PI_Q30) / ROM_DIV;
      sum  = longint'(x);
      term = x;
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 6;
      sum  = sum - longint'(term);
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 20;
      sum  = sum + longint'(term);
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 42;
      sum  = sum - longint'(term);
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 72;
      sum  = sum + longint'(term);
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 110;
      sum  = sum - longint'(term);
      if (sum < 0) begin
        sum = 0;
      end
      v = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
      rom[k] = (v > 64'd32767) ? 16'd32767 : 16'(v);
    end
    return rom;
  endfunction

  function automatic logic [WORD_W-1:0] header_word(input logic [POS_W-1:0] pos,
                                                    input logic [IDX_W-1:0] n);
    logic [31:0] data_bytes;
    logic [31:0] riff_size;
    data_bytes = {{(32 - IDX_W - 1){1'b0}}, n, 1'b0};
    riff_size  = data_bytes + 32'd36;
    unique case (pos)
      5'd0:    header_word = 16'h4952;
      5'd1:    header_word = 16'h4646;
      5'd2:    header_word = riff_size[15:0];
      5'd3:    header_word = riff_size[31:16];
      5'd4:    header_word = 16'h4157;
      5'd5:    header_word = 16'h4556;
      5'd6:    header_word = 16'h6D66;
      5'd7:    header_word = 16'h2074;
      5'd8:    header_word = 16'd16;
      5'd9:    header_word = 16'd0;
      5'd10:   header_word = 16'd1;
      5'd11:   header_word = 16'd1;
      5'd12:   header_word = RATE_V[15:0];
      5'd13:   header_word = RATE_V[31:16];
      5'd14:   header_word = BYTE_RATE_V[15:0];
      5'd15:   header_word = BYTE_RATE_V[31:16];
      5'd16:   header_word = 16'd2;
      5'd17:   header_word = 16'd16;
      5'd18:   header_word = 16'h6164;
      5'd19:   header_word = 16'h6174;
      5'd20:   header_word = data_bytes[15:0];
      default: header_word = data_bytes[31:16];
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/enveloped_sine_wav_stream_core.sv =====
// enveloped sine wav stream top level: apb registers, stream sequencer, output register
// header or idle word: result register, then output register once the output is free; one transaction at a time
// sample word: 6-stage sample unit, then result register and output register; one sample at a time
// any register write stalls input while the sample count is recomputed
// reset clears registers, stream state and output valid; depends on esws_pkg, esws_sample_unit
`default_nettype none

module enveloped_sine_wav_stream_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [esws_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         restart_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [esws_pkg::WORD_W-1:0]  word_o,
  output logic                         is_header_o,
  output logic                         last_o,
  output logic                         idle_o
);
  import esws_pkg::*;

  logic                cfg_wr;
  logic [31:0]         phase_step_q;
  logic [DUR_W-1:0]    duration_q;
  logic [WAIT_W-1:0]   cfg_wait_q, cfg_wait_d;
  logic [Y_W-1:0]      y_q;
  logic [Y_W-1:0]      nest_q;
  logic [IDX_W-1:0]    n_q;
  logic [NPROD_W-1:0]  nprod;
  logic [Y_W-1:0]      nrem;
  logic [Y_W-1:0]      ncorr;

  state_e              state_q, state_d;
  logic                active_q, active_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [IDX_W-1:0]    sidx_q, sidx_d;
  logic [31:0]         phase_q, phase_d;
  logic [WORD_W-1:0]   res_word_q, res_word_d;
  logic                res_hdr_q, res_hdr_d;
  logic                res_last_q, res_last_d;
  logic                res_idle_q, res_idle_d;

  logic                out_valid_q;
  logic [WORD_W-1:0]   word_q;
  logic                is_header_q, last_q, idle_q;

  logic                out_free;
  logic                in_acc;
  logic                out_load;
  logic                smp_start;
  logic                eff_act;
  logic [POS_W-1:0]    eff_pos;
  logic [IDX_W-1:0]    eff_sidx;
  logic [31:0]         eff_phase;
  logic [IDX_W-1:0]    rem;
  smp_req_t            smp_req;
  smp_rsp_t            smp_rsp;

  // configuration port
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    unique case (reg_e'(paddr[REG_SEL_BIT]))
      REG_PHASE_STEP: prdata = phase_step_q;
      REG_DURATION:   prdata = 32'(duration_q);
    endcase
  end

  always_comb begin
    if (cfg_wr) begin
      cfg_wait_d = WAIT_W'(NCNT_LAT);
    end else if (cfg_wait_q != '0) begin
      cfg_wait_d = cfg_wait_q - WAIT_W'(1);
    end else begin
      cfg_wait_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= '0;
      duration_q   <= '0;
      cfg_wait_q   <= '0;
    end else begin
      cfg_wait_q <= cfg_wait_d;
      if (cfg_wr) begin
        unique case (reg_e'(paddr[REG_SEL_BIT]))
          REG_PHASE_STEP: phase_step_q <= pwdata;
          REG_DURATION:   duration_q   <= pwdata[DUR_W-1:0];
        endcase
      end
    end
  end

  // sample count: scale, reciprocal estimate, correct and saturate
  always_comb begin
    nprod = NPROD_W'(y_q) * NPROD_W'(DEN_RECIP);
    nrem  = y_q - Y_W'(nest_q * Y_W'(RATE_DEN));
    ncorr = (nrem >= Y_W'(RATE_DEN)) ? nest_q + Y_W'(1) : nest_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_q    <= '0;
      nest_q <= '0;
      n_q    <= '0;
    end else begin
      y_q    <= Y_W'(duration_q) * Y_W'(RATE_NUM);
      nest_q <= nprod[NPROD_W-1:32];
      n_q    <= (ncorr > Y_W'(INDEX_MAX)) ? INDEX_MAX : ncorr[IDX_W-1:0];
    end
  end

  // stream sequencer
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !(state_q == ST_READY && cfg_wait_q == '0);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    eff_act   = restart_i || active_q;
    eff_pos   = restart_i ? '0 : pos_q;
    eff_sidx  = restart_i ? '0 : sidx_q;
    eff_phase = restart_i ? '0 : phase_q;
    rem       = n_q - eff_sidx;
    smp_req.tbl_idx = eff_phase[29 -: SINE_IDX_W] ^ {SINE_IDX_W{eff_phase[30]}};
    smp_req.neg     = eff_phase[31];
    smp_req.ramp_a  = (eff_sidx < IDX_W'(RAMP_LEN)) ? RAMP_W'(eff_sidx) : RAMP_W'(RAMP_LEN);
    smp_req.ramp_b  = (rem < IDX_W'(RAMP_LEN)) ? RAMP_W'(rem) : RAMP_W'(RAMP_LEN);
  end

  always_comb begin
    state_d    = state_q;
    active_d   = active_q;
    pos_d      = pos_q;
    sidx_d     = sidx_q;
    phase_d    = phase_q;
    res_word_d = res_word_q;
    res_hdr_d  = res_hdr_q;
    res_last_d = res_last_q;
    res_idle_d = res_idle_q;
    smp_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_READY: begin
        if (in_acc) begin
          active_d   = eff_act;
          pos_d      = eff_pos;
          sidx_d     = eff_sidx;
          phase_d    = eff_phase;
          res_word_d = '0;
          res_hdr_d  = 1'b0;
          res_last_d = 1'b0;
          res_idle_d = 1'b0;
          state_d    = ST_PUT;
          if (!eff_act) begin
            res_idle_d = 1'b1;
          end else if (eff_pos < POS_W'(HEADER_WORDS)) begin
            res_word_d = header_word(eff_pos, n_q);
            res_hdr_d  = 1'b1;
            res_last_d = (eff_pos == POS_W'(HEADER_WORDS - 1)) && (n_q == '0);
            active_d   = !res_last_d;
            pos_d      = eff_pos + POS_W'(1);
          end else if (eff_sidx >= n_q) begin
            active_d   = 1'b0;
            res_idle_d = 1'b1;
          end else begin
            smp_start  = 1'b1;
            res_last_d = (eff_sidx == n_q - IDX_W'(1));
            active_d   = !res_last_d;
            sidx_d     = eff_sidx + IDX_W'(1);
            phase_d    = eff_phase + phase_step_q;
            state_d    = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        if (smp_rsp.done) begin
          res_word_d = smp_rsp.word;
          state_d    = ST_PUT;
        end
      end
      ST_PUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_READY;
        end
      end
      default: begin
        state_d = ST_READY;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_READY;
      active_q <= 1'b0;
      pos_q    <= '0;
      sidx_q   <= '0;
      phase_q  <= '0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      pos_q    <= pos_d;
      sidx_q   <= sidx_d;
      phase_q  <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_word_q <= res_word_d;
    res_hdr_q  <= res_hdr_d;
    res_last_q <= res_last_d;
    res_idle_q <= res_idle_d;
  end

  esws_sample_unit u_sample (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (smp_start),
    .req_i   (smp_req),
    .rsp_o   (smp_rsp)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      word_q      <= res_word_q;
      is_header_q <= res_hdr_q;
      last_q      <= res_last_q;
      idle_q      <= res_idle_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign word_o      = word_q;
  assign is_header_o = is_header_q;
  assign last_o      = last_q;
  assign idle_o      = idle_q;

`ifndef NO_ASSERTIONS
  a_smp_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_start |-> ##SAMPLE_LAT smp_rsp.done)
    else $error("sample unit latency mismatch");
  a_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_rsp.done |-> state_q == ST_CALC)
    else $error("sample result arrived outside calc state");
  a_cfg_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> in_stall_o)
    else $error("input taken while sample count is recomputed");
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(HEADER_WORDS))
    else $error("header position out of range");
  a_idle_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && idle_o |-> word_o == '0 && !is_header_o && !last_o)
    else $error("idle transaction carries data");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/esws_sample_unit.sv =====
// sample datapath: quarter-wave sine rom, attack/release envelope, amplitude scaling
// depends on esws_pkg
`default_nettype none

module esws_sample_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  esws_pkg::smp_req_t req_i,
  output esws_pkg::smp_rsp_t rsp_o
);
  import esws_pkg::*;

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  logic [SAMPLE_LAT-1:0] vld_q;
  smp_req_t              req_q;
  logic [WORD_W-1:0]     rom_q;
  logic [PROD_W-1:0]     prod_q;
  logic [EST_W-1:0]      est_q;
  logic [ENV_FRAC-1:0]   env_q;
  logic [MAG_W-1:0]      mag_env_q;
  logic [WORD_W-1:0]     word_q;

  logic [EPROD_W-1:0]    eprod;
  logic [SC_W-1:0]       scaled;
  logic [SC_W-1:0]       emul;
  logic [SC_W-1:0]       erem;
  logic [EST_W-1:0]      ecorr;
  logic [AP_W-1:0]       aprod;
  logic [WORD_W-1:0]     mag16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[SAMPLE_LAT-2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      req_q <= req_i;
    end
  end

  // sine rom, registered read
  always_ff @(posedge clk_i) begin
    rom_q <= SINE_ROM[req_q.tbl_idx];
  end

  always_comb begin
    eprod  = EPROD_W'(prod_q) * EPROD_W'(ENV_RECIP);
    scaled = SC_W'(prod_q) << ENV_FRAC;
    emul   = SC_W'(est_q) * SC_W'(RAMP_SQ);
    erem   = scaled - emul;
    ecorr  = (erem >= SC_W'(RAMP_SQ)) ? est_q + EST_W'(1) : est_q;
    aprod  = AP_W'(mag_env_q) * AP_W'(AMPLITUDE);
    mag16  = WORD_W'(aprod[AP_W-1:AMP_SHIFT]);
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= PROD_W'(req_q.ramp_a) * PROD_W'(req_q.ramp_b);
    est_q     <= eprod[EPROD_W-1:ENV_SHIFT-ENV_FRAC];
    env_q     <= (ecorr[EST_W-1:ENV_FRAC] != '0) ? '1 : ecorr[ENV_FRAC-1:0];
    mag_env_q <= MAG_W'(rom_q[14:0]) * MAG_W'(env_q);
    word_q    <= req_q.neg ? (WORD_W'(0) - mag16) : mag16;
  end

  assign rsp_o.done = vld_q[SAMPLE_LAT-1];
  assign rsp_o.word = word_q;

`ifndef NO_ASSERTIONS
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vld_q) <= 1)
    else $error("more than one sample in the datapath");
  a_start_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> vld_q[0] && $countones(vld_q) == 1)
    else $error("sample start collided with a busy datapath");
  a_env_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] && (req_q.ramp_a == '0 || req_q.ramp_b == '0) |-> env_q == '0)
    else $error("envelope not zero at ramp end");
`endif

endmodule

`default_nettype wire
